FILE: rtl/core/dpd_pkg.sv
// Package for the debug packet deframer: character codes, phase codes,
// event codes and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpd_pkg;

    localparam int ByteW  = 8;
    localparam int EventW = 3;
    localparam int PhaseW = 3;
    localparam int NibW   = 4;

    typedef logic [ByteW-1:0]  byte_t;
    typedef logic [EventW-1:0] event_t;
    typedef logic [PhaseW-1:0] phase_t;
    typedef logic [NibW-1:0]   nib_t;

    localparam byte_t ESCAPE_XOR = 8'h20;
    localparam byte_t CH_ESCAPE  = 8'h7D;
    localparam byte_t CH_END     = 8'h23;
    localparam byte_t CH_START   = 8'h24;
    localparam byte_t CH_ACK     = 8'h2B;
    localparam byte_t CH_NACK    = 8'h2D;

    localparam phase_t PH_IDLE = 3'd0;
    localparam phase_t PH_BODY = 3'd1;
    localparam phase_t PH_ESC  = 3'd2;
    localparam phase_t PH_CSHI = 3'd3;
    localparam phase_t PH_CSLO = 3'd4;

    localparam event_t EV_PAYLOAD = 3'd0;
    localparam event_t EV_GOOD    = 3'd1;
    localparam event_t EV_BAD     = 3'd2;
    localparam event_t EV_ACK     = 3'd3;
    localparam event_t EV_NACK    = 3'd4;
    localparam event_t EV_ERROR   = 3'd5;

    typedef struct packed {
        logic ok;
        nib_t value;
    } hex_t;

    function automatic hex_t hex_decode(input byte_t b);
        hex_t h;
        h.ok    = 1'b0;
        h.value = '0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.ok    = 1'b1;
            h.value = NibW'(b - 8'h30);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            h.ok    = 1'b1;
            h.value = NibW'(b - 8'h37);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            h.ok    = 1'b1;
            h.value = NibW'(b - 8'h57);
        end
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/debug_packet_deframer.sv
// rx_byte goes into the input register, then its result into the output registers.
// Throughput: one item per cycle unless stalled; bytes with no result take one slot.
// Reset: rst_n clears the phase to idle, the running sum and the stored checksum digit,
// and empties both registers.
// Depends on dpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module debug_packet_deframer
    import dpd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [ByteW-1:0]    rx_byte,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [EventW-1:0]        event_res,
    output logic [ByteW-1:0]         payload
);

    logic   in_valid_reg;
    byte_t  in_byte_reg;
    phase_t phase_reg, phase_next;
    byte_t  sum_reg, sum_next;
    nib_t   cshi_reg, cshi_next;
    logic   out_valid_reg;
    event_t event_reg;
    byte_t  payload_reg;

    logic   emit;
    event_t ev;
    byte_t  pl;
    logic   out_free;
    logic   advance;
    hex_t   hx;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        cshi_next  = cshi_reg;
        emit       = 1'b0;
        ev         = EV_ERROR;
        pl         = '0;
        hx         = hex_decode(in_byte_reg);
        case (phase_reg)
            PH_BODY:
            begin
                if (in_byte_reg == CH_ESCAPE)
                begin
                    sum_next   = sum_reg + in_byte_reg;
                    phase_next = PH_ESC;
                end
                else if (in_byte_reg == CH_END)
                begin
                    phase_next = PH_CSHI;
                end
                else
                begin
                    sum_next = sum_reg + in_byte_reg;
                    emit     = 1'b1;
                    ev       = EV_PAYLOAD;
                    pl       = in_byte_reg;
                end
            end
            PH_ESC:
            begin
                sum_next   = sum_reg + in_byte_reg;
                phase_next = PH_BODY;
                emit       = 1'b1;
                ev         = EV_PAYLOAD;
                pl         = in_byte_reg ^ ESCAPE_XOR;
            end
            PH_CSHI:
            begin
                if (hx.ok)
                begin
                    cshi_next  = hx.value;
                    phase_next = PH_CSLO;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    ev         = EV_ERROR;
                end
            end
            PH_CSLO:
            begin
                phase_next = PH_IDLE;
                emit       = 1'b1;
                if (!hx.ok)
                    ev = EV_ERROR;
                else if ({cshi_reg, hx.value} == sum_reg)
                    ev = EV_GOOD;
                else
                    ev = EV_BAD;
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (in_byte_reg == CH_ACK)
                begin
                    emit = 1'b1;
                    ev   = EV_ACK;
                end
                else if (in_byte_reg == CH_NACK)
                begin
                    emit = 1'b1;
                    ev   = EV_NACK;
                end
                else if (in_byte_reg == CH_START)
                begin
                    sum_next   = '0;
                    phase_next = PH_BODY;
                end
                else
                begin
                    emit = 1'b1;
                    ev   = EV_ERROR;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            sum_reg       <= '0;
            cshi_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                cshi_reg  <= cshi_next;
            end
            if (out_free)
                out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_byte_reg <= rx_byte;
        if (advance && emit)
        begin
            event_reg   <= ev;
            payload_reg <= pl;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign payload   = payload_reg;

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_CSLO)
        else $error("phase left the legal range");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && event_reg != EV_PAYLOAD |-> payload_reg == '0)
        else $error("payload not zero on a non-payload event");

    a_frame_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_CSLO |=> phase_reg == PH_IDLE && out_valid_reg)
        else $error("frame end did not return to idle with a result");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> event_reg <= EV_ERROR)
        else $error("event code out of range");

endmodule

`default_nettype wire
